### rtl/icmp_echo_reply_checker_top_assert.svh
// Assertion macros for the ICMP echo reply checker.
// Depends on signals clk and arst_n in the scope where a macro is used.
`ifndef ICMP_ECHO_REPLY_CHECKER_TOP_ASSERT_SVH
`define ICMP_ECHO_REPLY_CHECKER_TOP_ASSERT_SVH

// Condition implies consequence in the same cycle.
`define IERC_ASSERT_SAME(lbl, cond, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error("ierc assertion failed");

// Condition implies consequence in the next cycle.
`define IERC_ASSERT_NEXT(lbl, cond, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error("ierc assertion failed");

`endif

### rtl/ierc_pkg.sv
// Shared types and constants of the ICMP echo reply checker.
// No dependencies.
package ierc_pkg;

	localparam int BYTE_IDX_W = 13;

	localparam logic [1:0] VERDICT_ACCEPT    = 2'd0;
	localparam logic [1:0] VERDICT_IGNORE    = 2'd1;
	localparam logic [1:0] VERDICT_INVALID   = 2'd2;
	localparam logic [1:0] VERDICT_DUPLICATE = 2'd3;

	localparam logic CFG_PEER_ADDR  = 1'b0;
	localparam logic CFG_ECHO_IDENT = 1'b1;

	localparam logic [15:0] FRAG_MASK   = 16'h3fff;
	localparam logic [15:0] SUM_OK      = 16'hffff;
	localparam logic [15:0] SAT_MAX     = 16'd65535;
	localparam logic [5:0]  MIN_HDR     = 6'd20;
	localparam logic [12:0] MIN_PACKET  = 13'd28;
	localparam logic [3:0]  IPV4_VER    = 4'd4;

	typedef struct packed {
		logic [BYTE_IDX_W-1:0] idx;
		logic [5:0]            hdr;
		logic [15:0]           plen;
		logic [15:0]           sum;
		logic [7:0]            hold;
		logic [15:0]           seq;
		logic [63:0]           etime;
		logic [1:0]            flags;
	} pkt_t;

	typedef struct packed {
		logic        time_we;
		logic        seen_we;
		logic        seen_val;
		logic [15:0] addr;
		logic [63:0] time_val;
	} st_wr_t;

endpackage

### rtl/ierc_if.sv
// Request and result channel interfaces of the ICMP echo reply checker.
// No dependencies.
interface ierc_in_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [7:0]  data_byte;
	logic        last;
	logic [31:0] source_addr;
	logic [63:0] time_us;
	modport source (output valid, cmd, data_byte, last, source_addr, time_us, input ready);
	modport sink (input valid, cmd, data_byte, last, source_addr, time_us, output ready);
endinterface

interface ierc_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  verdict;
	logic [15:0] sequence_res;
	logic [63:0] rtt_us;
	logic [13:0] sent_count;
	logic [13:0] received_count;
	logic [15:0] duplicate_count;
	logic [15:0] invalid_count;
	modport source (output valid, verdict, sequence_res, rtt_us, sent_count, received_count,
		duplicate_count, invalid_count, input ready);
	modport sink (input valid, verdict, sequence_res, rtt_us, sent_count, received_count,
		duplicate_count, invalid_count, output ready);
endinterface

### rtl/ierc_parse.sv
// Streaming IPv4/ICMP byte parser: header fields, checksum, timestamp, pattern.
// Depends on ierc_pkg.
module ierc_parse #(
	parameter int PAYLOAD_BYTES = 512,
	parameter int RECEIVE_LIMIT = 2048
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic              last,
	input  logic [7:0]        data_byte,
	input  logic [15:0]       echo_ident,
	output ierc_pkg::pkt_t    cur,
	output ierc_pkg::pkt_t    nxt
);
	localparam int ECHO_LEN = 8 + PAYLOAD_BYTES;
	localparam int IW = ierc_pkg::BYTE_IDX_W;

	ierc_pkg::pkt_t pkt_q;
	logic           take;
	logic [15:0]    word;
	logic [IW-1:0]  k;
	logic           inwin;
	logic [15:0]    add;
	logic [16:0]    s17;
	logic [7:0]     want;

	assign cur  = pkt_q;
	assign take = fire && (pkt_q.idx < IW'(RECEIVE_LIMIT));
	assign word = {pkt_q.hold, data_byte};

	always_comb begin
		nxt   = pkt_q;
		k     = '0;
		inwin = 1'b0;
		add   = '0;
		s17   = '0;
		want  = '0;
		if (take) begin
			if (pkt_q.idx == '0) begin
				if (data_byte[7:4] != ierc_pkg::IPV4_VER) nxt.flags[0] = 1'b1;
				nxt.hdr = {data_byte[3:0], 2'b00};
			end
			if (pkt_q.idx == IW'(3)) nxt.plen = word;
			if (pkt_q.idx == IW'(7) && (word & ierc_pkg::FRAG_MASK) != '0) nxt.flags[0] = 1'b1;
			k     = pkt_q.idx - IW'(nxt.hdr);
			inwin = (nxt.hdr >= ierc_pkg::MIN_HDR) && (pkt_q.idx >= IW'(nxt.hdr))
				&& (k < IW'(ECHO_LEN));
			if (inwin) begin
				if (k[0]) add = word;
				else if (k == IW'(ECHO_LEN - 1)) add = {data_byte, 8'h00};
				s17 = {1'b0, pkt_q.sum} + {1'b0, add};
				nxt.sum = s17[16] ? (s17[15:0] + 16'd1) : s17[15:0];
				if ((k == IW'(0) || k == IW'(1)) && data_byte != '0) nxt.flags[0] = 1'b1;
				if (k == IW'(5) && word != echo_ident) nxt.flags[0] = 1'b1;
				if (k == IW'(7)) nxt.seq = word;
				for (int e = 0; e < 8; e++) begin
					if (k == IW'(8 + e)) nxt.etime[8*e +: 8] = pkt_q.etime[8*e +: 8] | data_byte;
				end
				want = (k[7:0] - 8'd8) ^ pkt_q.seq[7:0] ^ echo_ident[15:8];
				if (k >= IW'(16) && data_byte != want) nxt.flags[1] = 1'b1;
			end
			nxt.hold = data_byte;
			nxt.idx  = pkt_q.idx + IW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_q <= '0;
		end else if (fire && last) begin
			pkt_q <= '0;
		end else if (take) begin
			pkt_q <= nxt;
		end
	end
endmodule

### rtl/ierc_store.sv
// Send-time and reply-seen memories with registered, write-bypassed reads.
// Depends on ierc_pkg.
module ierc_store #(
	parameter int MAX_SENT = 8192
) (
	input  logic             clk,
	input  ierc_pkg::st_wr_t wr,
	input  logic [15:0]      rd_addr,
	output logic [63:0]      rd_time,
	output logic             rd_seen
);
	localparam int AW = (MAX_SENT > 1) ? $clog2(MAX_SENT) : 1;

	logic [63:0] time_mem [MAX_SENT];
	logic        seen_mem [MAX_SENT];
	logic [AW-1:0] wa;
	logic [AW-1:0] ra;

	assign wa = wr.addr[AW-1:0];
	assign ra = rd_addr[AW-1:0];

	always_ff @(posedge clk) begin
		if (wr.time_we) time_mem[wa] <= wr.time_val;
		if (wr.time_we && wa == ra) rd_time <= wr.time_val;
		else rd_time <= time_mem[ra];
	end

	always_ff @(posedge clk) begin
		if (wr.seen_we) seen_mem[wa] <= wr.seen_val;
		if (wr.seen_we && wa == ra) rd_seen <= wr.seen_val;
		else rd_seen <= seen_mem[ra];
	end
endmodule

### rtl/icmp_echo_reply_checker_top.sv
// Order: a request is taken into the input register; when its byte ends a packet and
// the result register is free or being emptied, its verdict goes into the result register.
// Throughput: one request per cycle; a stalled result holds the input register, which
// then holds off new requests until the result is taken.
// Reset (arst_n, asynchronous): counters, packet parser state, config and valid flags
// clear at once; the seen map is cleared per entry as each send is recorded, so no sweep.
module icmp_echo_reply_checker_top #(
	parameter int MAX_SENT      = 8192,
	parameter int PAYLOAD_BYTES = 512,
	parameter int RECEIVE_LIMIT = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	ierc_in_if.sink     in_req,
	ierc_out_if.source  out_res,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);
	localparam int SW = $clog2(MAX_SENT + 1);
	localparam int ECHO_LEN = 8 + PAYLOAD_BYTES;

	// input stage
	logic        valid_s1;
	logic        cmd_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic [31:0] src_s1;
	logic [63:0] time_s1;

	logic [31:0] peer_q;
	logic [15:0] ident_q;
	logic [SW-1:0] sends_q;
	logic [SW-1:0] replies_q;
	logic [15:0] dup_q;
	logic [15:0] bad_q;

	logic fire;
	logic fire_byte;
	logic fire_send;
	logic fire_end;

	ierc_pkg::pkt_t   pkt_cur;
	ierc_pkg::pkt_t   pkt_nxt;
	ierc_pkg::st_wr_t st_wr;
	logic [63:0]      rd_time;
	logic             rd_seen;

	logic [1:0]  verdict;
	logic        ignore;
	logic        bad_seq;
	logic        bad_body;
	logic [15:0] seq_m1;

	// advance the input stage whenever the result register is free or being emptied
	assign fire      = valid_s1 && (!out_res.valid || out_res.ready);
	assign in_req.ready = !valid_s1 || fire;
	assign fire_byte = fire && cmd_s1;
	assign fire_send = fire && !cmd_s1 && (sends_q < SW'(MAX_SENT));
	assign fire_end  = fire_byte && last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_req.ready) begin
			valid_s1 <= in_req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_req.ready && in_req.valid) begin
			cmd_s1  <= in_req.cmd;
			byte_s1 <= in_req.data_byte;
			last_s1 <= in_req.last;
			src_s1  <= in_req.source_addr;
			time_s1 <= in_req.time_us;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peer_q  <= '0;
			ident_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				ierc_pkg::CFG_PEER_ADDR:  peer_q  <= cfg_data;
				ierc_pkg::CFG_ECHO_IDENT: ident_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	ierc_parse #(
		.PAYLOAD_BYTES(PAYLOAD_BYTES),
		.RECEIVE_LIMIT(RECEIVE_LIMIT)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire_byte),
		.last      (last_s1),
		.data_byte (byte_s1),
		.echo_ident(ident_q),
		.cur       (pkt_cur),
		.nxt       (pkt_nxt)
	);

	// the sequence settles long before the last byte of any packet that passes the
	// header checks, so read the tables from the held sequence every cycle
	assign seq_m1 = pkt_cur.seq - 16'd1;

	always_comb begin
		st_wr          = '0;
		st_wr.time_val = time_s1;
		if (fire_send) begin
			st_wr.time_we  = 1'b1;
			st_wr.seen_we  = 1'b1;
			st_wr.seen_val = 1'b0;
			st_wr.addr     = 16'(sends_q);
		end else if (fire_end && verdict == ierc_pkg::VERDICT_ACCEPT) begin
			st_wr.seen_we  = 1'b1;
			st_wr.seen_val = 1'b1;
			st_wr.addr     = pkt_nxt.seq - 16'd1;
		end
	end

	ierc_store #(
		.MAX_SENT(MAX_SENT)
	) u_store (
		.clk    (clk),
		.wr     (st_wr),
		.rd_addr(seq_m1),
		.rd_time(rd_time),
		.rd_seen(rd_seen)
	);

	// verdict on the final byte, checks in priority order
	always_comb begin
		ignore = (src_s1 != peer_q) || (pkt_nxt.idx < ierc_pkg::MIN_PACKET)
			|| pkt_nxt.flags[0] || (pkt_nxt.hdr < ierc_pkg::MIN_HDR)
			|| (pkt_nxt.plen != (16'(pkt_nxt.hdr) + 16'(ECHO_LEN)))
			|| (16'(pkt_nxt.idx) < pkt_nxt.plen);
		bad_seq = (pkt_nxt.seq == '0) || (17'(pkt_nxt.seq) > 17'(sends_q))
			|| (17'(pkt_nxt.seq) > 17'(MAX_SENT)) || (pkt_nxt.sum != ierc_pkg::SUM_OK);
		bad_body = (pkt_nxt.etime != rd_time) || pkt_nxt.flags[1];
		if (ignore) verdict = ierc_pkg::VERDICT_IGNORE;
		else if (bad_seq || bad_body) verdict = ierc_pkg::VERDICT_INVALID;
		else if (rd_seen) verdict = ierc_pkg::VERDICT_DUPLICATE;
		else verdict = ierc_pkg::VERDICT_ACCEPT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sends_q   <= '0;
			replies_q <= '0;
			dup_q     <= '0;
			bad_q     <= '0;
		end else begin
			if (fire_send) sends_q <= sends_q + SW'(1);
			if (fire_end) begin
				case (verdict)
					ierc_pkg::VERDICT_ACCEPT:    replies_q <= replies_q + SW'(1);
					ierc_pkg::VERDICT_INVALID:
						if (bad_q != ierc_pkg::SAT_MAX) bad_q <= bad_q + 16'd1;
					ierc_pkg::VERDICT_DUPLICATE:
						if (dup_q != ierc_pkg::SAT_MAX) dup_q <= dup_q + 16'd1;
					default: ;
				endcase
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_res.valid <= 1'b0;
		end else if (fire_end) begin
			out_res.valid <= 1'b1;
		end else if (out_res.ready) begin
			out_res.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_end) begin
			out_res.verdict         <= verdict;
			out_res.sequence_res    <= pkt_nxt.seq;
			out_res.rtt_us          <= (verdict == ierc_pkg::VERDICT_ACCEPT) ?
				(time_s1 - rd_time) : 64'd0;
			out_res.sent_count      <= 14'(sends_q);
			out_res.received_count  <= 14'(replies_q + ((verdict == ierc_pkg::VERDICT_ACCEPT)
				? SW'(1) : SW'(0)));
			out_res.duplicate_count <= (verdict == ierc_pkg::VERDICT_DUPLICATE
				&& dup_q != ierc_pkg::SAT_MAX) ? dup_q + 16'd1 : dup_q;
			out_res.invalid_count   <= (verdict == ierc_pkg::VERDICT_INVALID
				&& bad_q != ierc_pkg::SAT_MAX) ? bad_q + 16'd1 : bad_q;
		end
	end
endmodule

### rtl/ierc_checker.sv
// Port-level checks on the result channel of the ICMP echo reply checker.
// Depends on ierc_pkg and icmp_echo_reply_checker_top_assert.svh; bound to the top level.
`include "icmp_echo_reply_checker_top_assert.svh"
module ierc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  verdict,
	input logic [15:0] sequence_res,
	input logic [63:0] rtt_us,
	input logic [13:0] sent_count,
	input logic [13:0] received_count
);
	`IERC_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(verdict))
	`IERC_ASSERT_SAME(a_rtt_zero, out_valid && verdict != ierc_pkg::VERDICT_ACCEPT, rtt_us == '0)
	`IERC_ASSERT_SAME(a_seq_set, out_valid && verdict == ierc_pkg::VERDICT_ACCEPT, sequence_res != '0)
	`IERC_ASSERT_SAME(a_recv_le_sent, out_valid, received_count <= sent_count)
endmodule

bind icmp_echo_reply_checker_top ierc_checker u_ierc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_res.valid),
	.out_ready     (out_res.ready),
	.verdict       (out_res.verdict),
	.sequence_res  (out_res.sequence_res),
	.rtt_us        (out_res.rtt_us),
	.sent_count    (out_res.sent_count),
	.received_count(out_res.received_count)
);

### dv/testbench.sv
// Self-checking testbench for the ICMP echo reply checker.
// Depends on rtl/ierc_pkg.sv, rtl/ierc_if.sv and rtl/icmp_echo_reply_checker_top.sv.
`timescale 1ns / 1ps

module testbench;

	localparam int TABLE_DEPTH = 8192;
	localparam int ECHO_BYTES  = 8 + 512;
	localparam int BYTE_CAP    = 2048;

	// Damage applied to a generated echo reply
	localparam int DMG_NONE     = 0;
	localparam int DMG_SOURCE   = 1;
	localparam int DMG_IDENT    = 2;
	localparam int DMG_CHECKSUM = 3;
	localparam int DMG_STAMP    = 4;
	localparam int DMG_PATTERN  = 5;
	localparam int DMG_TRUNCATE = 6;
	localparam int DMG_FRAGMENT = 7;
	localparam int DMG_TYPE     = 8;
	localparam int DMG_VERSION  = 9;

	// Idling modes
	localparam int IDLE_NONE   = 0;
	localparam int IDLE_SENDER = 1;
	localparam int IDLE_RECV   = 2;
	localparam int IDLE_BOTH   = 3;

	typedef struct packed {
		logic [1:0]  verdict;
		logic [15:0] seq;
		logic [63:0] rtt;
		logic [13:0] sent;
		logic [13:0] recvd;
		logic [15:0] dups;
		logic [15:0] bads;
	} verdict_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [31:0] cfg_data;

	ierc_in_if  in_req();
	ierc_out_if out_res();

	icmp_echo_reply_checker_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_req   (in_req),
		.out_res  (out_res),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Shadow state of the checker
	logic [63:0] stamp_mem [TABLE_DEPTH];
	bit          seen_map  [TABLE_DEPTH];
	int          sends, replies, dups, bads;
	int          pos, hdr_len, tot_len, csum, prev_byte, echo_seq, flags;
	logic [63:0] echo_stamp;
	logic [31:0] peer;
	logic [15:0] ident;

	verdict_t verdicts_due[$];
	int       errors;
	int       idle_mode;
	int       items_sent;
	bit       hold_go;
	int       hold_left;

	function automatic void clear_parse();
		pos = 0; hdr_len = 0; tot_len = 0; csum = 0; prev_byte = 0;
		echo_seq = 0; echo_stamp = '0; flags = 0;
	endfunction

	// Parse one received byte into the shadow packet state
	function automatic void parse_byte(input logic [7:0] b);
		int word, k, add;
		word = ((prev_byte & 8'hff) << 8) | b;
		if (pos == 0) begin
			if (b[7:4] != ierc_pkg::IPV4_VER) flags |= 1;
			hdr_len = b[3:0] * 4;
		end
		if (pos == 3) tot_len = word;
		if (pos == 7 && (word & ierc_pkg::FRAG_MASK) != 0) flags |= 1;
		if (hdr_len >= ierc_pkg::MIN_HDR && pos >= hdr_len && pos - hdr_len < ECHO_BYTES) begin
			k = pos - hdr_len;
			add = 0;
			if (k & 1) add = word;
			else if (k == ECHO_BYTES - 1) add = b << 8;
			csum += add;
			if (csum > 16'hffff) csum = (csum & 16'hffff) + 1;
			if ((k == 0 || k == 1) && b != 0) flags |= 1;
			if (k == 5 && word != ident) flags |= 1;
			if (k == 7) echo_seq = word;
			if (k >= 8 && k < 16) echo_stamp |= 64'(b) << (8 * (k - 8));
			if (k >= 16 && b != (((k - 8) ^ echo_seq ^ (ident >> 8)) & 8'hff)) flags |= 2;
		end
		prev_byte = b;
		pos++;
	endfunction

	// Advance the shadow state by one request; return 1 when a verdict is due
	function automatic bit predict_verdict(input bit cmd, input logic [7:0] b, input bit last,
			input logic [31:0] src, input logic [63:0] t, output verdict_t v);
		int seq;
		v = '0;
		if (!cmd) begin
			if (sends < TABLE_DEPTH) begin
				stamp_mem[sends] = t;
				sends++;
			end
			return 1'b0;
		end
		if (pos < BYTE_CAP) parse_byte(b);
		if (!last) return 1'b0;
		seq = echo_seq & 16'hffff;
		if (src != peer || pos < ierc_pkg::MIN_PACKET || flags[0] ||
				hdr_len < ierc_pkg::MIN_HDR || tot_len != hdr_len + ECHO_BYTES ||
				pos < tot_len) begin
			v.verdict = ierc_pkg::VERDICT_IGNORE;
		end else if (seq == 0 || seq > sends || seq > TABLE_DEPTH ||
				csum != ierc_pkg::SUM_OK || echo_stamp != stamp_mem[seq-1] || flags[1]) begin
			v.verdict = ierc_pkg::VERDICT_INVALID;
			if (bads < ierc_pkg::SAT_MAX) bads++;
		end else if (seen_map[seq-1]) begin
			v.verdict = ierc_pkg::VERDICT_DUPLICATE;
			if (dups < ierc_pkg::SAT_MAX) dups++;
		end else begin
			v.verdict = ierc_pkg::VERDICT_ACCEPT;
			seen_map[seq-1] = 1'b1;
			replies++;
			v.rtt = t - stamp_mem[seq-1];
		end
		v.seq   = 16'(seq);
		v.sent  = 14'(sends);
		v.recvd = 14'(replies);
		v.dups  = 16'(dups);
		v.bads  = 16'(bads);
		clear_parse();
		return 1'b1;
	endfunction

	// Offer one request, hold it until accepted, then log its expected verdict if one is due.
	// A typed row overrides the predicted verdict with the one given.
	task automatic put_req(input bit cmd, input logic [7:0] b, input bit last,
			input logic [31:0] src, input logic [63:0] t, input bit typed = 1'b0,
			input verdict_t typed_v = '0);
		verdict_t v;
		int pct;
		pct = (idle_mode == IDLE_SENDER) ? 69 : (idle_mode == IDLE_BOTH) ? 20 : 0;
		if ($urandom_range(99) < pct) begin
			in_req.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_req.valid       <= 1'b1;
		in_req.cmd         <= cmd;
		in_req.data_byte   <= b;
		in_req.last        <= last;
		in_req.source_addr <= src;
		in_req.time_us     <= t;
		do @(posedge clk); while (!in_req.ready);
		items_sent++;
		if (predict_verdict(cmd, b, last, src, t, v))
			verdicts_due.push_back(typed ? typed_v : v);
	endtask

	task automatic put_bytes(input logic [7:0] pkt[$], input logic [31:0] src);
		foreach (pkt[i])
			put_req(1'b1, pkt[i], i == pkt.size() - 1, src, {$urandom, $urandom});
	endtask

	task automatic record_send();
		put_req(1'b0, 8'($urandom), 1'($urandom), 32'($urandom), {$urandom, $urandom});
	endtask

	// Build an echo reply for seq with the given damage and stream it in
	task automatic send_reply(input int seq, input int dmg, input int ihl, input int extra = 0);
		logic [7:0]  pkt[$];
		logic [63:0] stamp;
		logic [31:0] src;
		int h, total, sum, at, cut;
		h = ihl * 4;
		total = h + ECHO_BYTES;
		stamp = (seq >= 1 && seq <= sends) ? stamp_mem[seq-1] : {$urandom, $urandom};
		if (dmg == DMG_STAMP) stamp ^= 64'd1 << $urandom_range(63);
		pkt.push_back({(dmg == DMG_VERSION) ? 4'($urandom_range(15)) : ierc_pkg::IPV4_VER,
			4'(ihl)});
		pkt.push_back(8'($urandom));
		pkt.push_back(total[15:8]);
		pkt.push_back(total[7:0]);
		pkt.push_back(8'($urandom));
		pkt.push_back(8'($urandom));
		// don't-fragment may stand; any offset or more-fragments bit is a fault
		pkt.push_back((dmg == DMG_FRAGMENT) ? 8'h20 : {1'b0, 1'($urandom), 6'd0});
		pkt.push_back(8'd0);
		pkt.push_back(8'($urandom));
		pkt.push_back(8'd1);
		for (int i = 10; i < h; i++) pkt.push_back(8'($urandom));
		pkt.push_back((dmg == DMG_TYPE) ? 8'(8 + $urandom_range(1)) : 8'd0);
		pkt.push_back((dmg == DMG_TYPE) ? 8'($urandom_range(1)) : 8'd0);
		pkt.push_back(8'd0);
		pkt.push_back(8'd0);
		pkt.push_back((dmg == DMG_IDENT) ? ~ident[15:8] : ident[15:8]);
		pkt.push_back(ident[7:0]);
		pkt.push_back(seq[15:8]);
		pkt.push_back(seq[7:0]);
		for (int i = 0; i < 8; i++) pkt.push_back(stamp[8*i +: 8]);
		for (int j = 8; j < 512; j++) pkt.push_back(8'(j ^ seq ^ (ident >> 8)));
		// break the pattern before the sum is taken so only the pattern check trips
		if (dmg == DMG_PATTERN) begin
			at = h + $urandom_range(16, ECHO_BYTES - 1);
			pkt[at] ^= 8'h80 >> $urandom_range(7);
		end
		// fill in the ICMP checksum
		sum = 0;
		for (int k = 0; k < ECHO_BYTES; k += 2) begin
			sum += {pkt[h+k], pkt[h+k+1]};
			sum = (sum & 16'hffff) + (sum >> 16);
		end
		sum = ~sum & 16'hffff;
		if (dmg == DMG_CHECKSUM) sum ^= 1 << $urandom_range(15);
		pkt[h+2] = sum[15:8];
		pkt[h+3] = sum[7:0];
		if (dmg == DMG_TRUNCATE) begin
			cut = $urandom_range(1, pkt.size() - 1);
			while (pkt.size() > cut) void'(pkt.pop_back());
		end
		for (int i = 0; i < extra; i++) pkt.push_back(8'($urandom));
		src = (dmg == DMG_SOURCE) ? peer ^ (32'd1 << $urandom_range(31)) : peer;
		put_bytes(pkt, src);
	endtask

	task automatic send_noise(input int len);
		logic [7:0] pkt[$];
		for (int i = 0; i < len; i++) pkt.push_back(8'($urandom));
		if ($urandom_range(1)) pkt[0] = {ierc_pkg::IPV4_VER, 4'($urandom_range(5, 15))};
		put_bytes(pkt, $urandom_range(1) ? peer : 32'($urandom));
	endtask

	// Drop the request, wait for every expected verdict, then let the pipeline drain
	task automatic drain();
		in_req.valid <= 1'b0;
		wait (verdicts_due.size() == 0);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == ierc_pkg::CFG_PEER_ADDR) peer = val;
		else ident = val[15:0];
	endtask

	task automatic compare_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	// Result side: check accepted verdicts, then choose ready for the next cycle
	always @(posedge clk) begin
		verdict_t want;
		int pct;
		if (arst_n && out_res.valid && out_res.ready) begin
			if (verdicts_due.size() == 0) begin
				$error("verdict with none expected");
				errors++;
			end else begin
				want = verdicts_due.pop_front();
				compare_field("verdict", 64'(want.verdict), 64'(out_res.verdict));
				compare_field("sequence_res", 64'(want.seq), 64'(out_res.sequence_res));
				compare_field("rtt_us", want.rtt, out_res.rtt_us);
				compare_field("sent_count", 64'(want.sent), 64'(out_res.sent_count));
				compare_field("received_count", 64'(want.recvd),
					64'(out_res.received_count));
				compare_field("duplicate_count", 64'(want.dups),
					64'(out_res.duplicate_count));
				compare_field("invalid_count", 64'(want.bads), 64'(out_res.invalid_count));
			end
		end
		if (hold_go) begin
			hold_left = 800;
			hold_go = 1'b0;
		end
		pct = (idle_mode == IDLE_RECV) ? 69 : (idle_mode == IDLE_BOTH) ? 20 : 0;
		if (hold_left > 0) begin
			hold_left--;
			out_res.ready <= 1'b0;
		end else begin
			out_res.ready <= ($urandom_range(99) >= pct);
		end
	end

	// Hard stop in case the block hangs
	initial begin
		#20ms;
		$display("status: fail");
		$finish;
	end

	initial begin
		typedef struct {
			bit          cmd;
			logic [7:0]  b;
			bit          last;
			logic [31:0] src;
			logic [63:0] t;
			bit          typed;
			verdict_t    v;
		} row_t;
		row_t rows[$];
		int   phase_start, pick, first_seq;

		in_req.valid       = 1'b0;
		in_req.cmd         = 1'b0;
		in_req.data_byte   = '0;
		in_req.last        = 1'b0;
		in_req.source_addr = '0;
		in_req.time_us     = '0;
		out_res.ready      = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = ierc_pkg::CFG_PEER_ADDR;
		cfg_data  = '0;
		hold_go   = 1'b0;
		hold_left = 0;
		errors    = 0;
		idle_mode = IDLE_NONE;
		items_sent = 0;
		first_seq = 1;
		sends = 0; replies = 0; dups = 0; bads = 0;
		peer = '0; ident = '0;
		foreach (seen_map[i]) seen_map[i] = 1'b0;
		clear_parse();

		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: lone bytes right after reset, send-time extremes, short packets.
		// Typed rows carry their verdict; the rest go through the predictor.
		rows.push_back('{1, 8'h45, 1, 32'h0, 64'h0, 1,
			'{ierc_pkg::VERDICT_IGNORE, 16'd0, 64'd0, 14'd0, 14'd0, 16'd0, 16'd0}});
		rows.push_back('{0, 8'hff, 1, 32'hffff_ffff, 64'h0, 0, '0});
		rows.push_back('{0, 8'h00, 0, 32'h0, 64'hffff_ffff_ffff_ffff, 0, '0});
		rows.push_back('{1, 8'hff, 1, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff, 1,
			'{ierc_pkg::VERDICT_IGNORE, 16'd0, 64'd0, 14'd2, 14'd0, 16'd0, 16'd0}});
		rows.push_back('{1, 8'h00, 0, 32'hffff_ffff, 64'h0, 0, '0});
		rows.push_back('{1, 8'h00, 1, 32'h0, 64'h0, 1,
			'{ierc_pkg::VERDICT_IGNORE, 16'd0, 64'd0, 14'd2, 14'd0, 16'd0, 16'd0}});
		for (int i = 0; i < 10; i++)
			rows.push_back('{1, 8'(i == 0 ? 8'h4f : 8'h5a), i == 9, 32'h0, 64'h1, 0, '0});
		foreach (rows[i])
			put_req(rows[i].cmd, rows[i].b, rows[i].last, rows[i].src, rows[i].t,
				rows[i].typed, rows[i].v);
		drain();

		// Random part: one phase per idling mode, each with its own registers
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin
					write_reg(ierc_pkg::CFG_PEER_ADDR, 32'h0);
					write_reg(ierc_pkg::CFG_ECHO_IDENT, 32'h0);
				end
				1: begin
					write_reg(ierc_pkg::CFG_PEER_ADDR, 32'hffff_ffff);
					write_reg(ierc_pkg::CFG_ECHO_IDENT, 32'h0000_ffff);
				end
				default: begin
					write_reg(ierc_pkg::CFG_PEER_ADDR, 32'($urandom));
					write_reg(ierc_pkg::CFG_ECHO_IDENT, 32'($urandom));
				end
			endcase
			idle_mode = p;
			phase_start = items_sent;
			repeat (3) record_send();
			while (items_sent - phase_start < 40) begin
				pick = $urandom_range(99);
				if (pick < 35) record_send();
				else send_noise($urandom_range(1, 40));
			end
			// once, hold the result side off while single-byte packets pile up
			if (p == 0) begin
				hold_go = 1'b1;
				for (int i = 0; i < 100; i++)
					put_req(1'b1, 8'($urandom), 1'b1, 32'($urandom), 64'($urandom));
			end
			case (p)
				0: begin
					first_seq = sends;
					send_reply(first_seq, DMG_NONE, 5);
				end
				1: send_reply($urandom_range(1, sends), $urandom_range(DMG_SOURCE, DMG_VERSION),
					$urandom_range(5, 15));
				// the reply of the first phase again, with a longer header
				2: send_reply(first_seq, DMG_NONE, $urandom_range(6, 15));
				default: send_reply($urandom_range(1, sends), DMG_TRUNCATE, 5);
			endcase
			drain();
		end

		idle_mode = IDLE_NONE;
		drain();
		repeat (20) @(posedge clk);
		if (errors == 0 && verdicts_due.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
